// ----- hw/rtl/ksd_pkg.sv -----
// Shared types, constants and layout tables for the keyboard scancode decoder.
`timescale 1ns / 1ps

package ksd_pkg;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result buffer geometry (power of two, pointers wrap naturally).
    localparam int OFIFO_DEPTH = 4;
    localparam int OF_ADDR_W   = $clog2(OFIFO_DEPTH);
    localparam int OF_CNT_W    = $clog2(OFIFO_DEPTH + 1);

    // Operation codes.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_INIT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_INIT_LOCKS = 1'b0;
    localparam logic CFG_LED_CMD    = 1'b1;

    localparam logic [7:0] LED_CMD_RESET = 8'd237;

    // Scan codes with a special meaning.
    localparam logic [7:0] SC_BACKSPACE   = 8'h0e;
    localparam logic [7:0] SC_ENTER       = 8'h1c;
    localparam logic [7:0] SC_TAB         = 8'h0f;
    localparam logic [7:0] SC_LSHIFT      = 8'h2a;
    localparam logic [7:0] SC_RSHIFT      = 8'h36;
    localparam logic [7:0] SC_LSHIFT_REL  = 8'haa;
    localparam logic [7:0] SC_RSHIFT_REL  = 8'hb6;
    localparam logic [7:0] SC_CAPS        = 8'h3a;
    localparam logic [7:0] SC_NUM         = 8'h45;
    localparam logic [7:0] SC_SCROLL      = 8'h46;
    localparam logic [7:0] SC_ACK         = 8'hfa;
    localparam logic [7:0] SC_RESEND      = 8'hfe;

    // Character codes reported for backspace and enter.
    localparam logic [7:0] CHR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHR_ENTER     = 8'd10;
    localparam logic [7:0] CHR_NONE      = 8'd0;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_CHAR  = 3'd0,
        KIND_BKSP  = 3'd1,
        KIND_ENTER = 3'd2,
        KIND_FOCUS = 3'd3,
        KIND_TX    = 3'd4
    } kind_t;

    // One result beat.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       focus;
        logic       last;
    } result_t;

    // Outcome of decoding one input item.
    typedef struct packed {
        logic       ev_valid;
        kind_t      ev_kind;
        logic [7:0] ev_value;
        logic [1:0] shift;
        logic [2:0] locks;
        logic       focus;
        logic       awaiting;
        logic       led_update;
    } step_t;

    // Plain layout, indexed by the low seven bits of the scan code.
    localparam logic [7:0] PLAIN_MAP [0:127] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h40, 8'h5b, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
    };

    // Shifted layout.
    localparam logic [7:0] SHIFT_MAP [0:127] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h60, 8'h7b, 8'h00, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
        8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
    };

endpackage

// ----- hw/rtl/keyboard_scancode_decoder.sv -----
// Keyboard scancode decoder: an item is decoded in its accept cycle; its result beats are registered
// in the result buffer. Throughput: one item per cycle while that buffer has room for two beats; an
// item that queues both LED bytes (lock key or init) holds off input while the second byte waits for
// the queue RAM's single write port. Up to two result beats per item drain at one beat per cycle,
// while out_ready is high, from a 4-entry result buffer. Reset clears the shift, lock, focus, queue
// pointer and handshake state at once; the queue RAM is never cleared, only read where written.
`timescale 1ns / 1ps

module keyboard_scancode_decoder (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] scan_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] value,
    output logic       focus,
    output logic       last
);

    localparam int AW = ksd_pkg::QADDR_W;
    localparam int CW = ksd_pkg::QCNT_W;

    // Architectural state.
    logic [1:0]     shift_reg;
    logic [2:0]     lock_reg;
    logic           focus_reg;
    logic           await_reg;
    logic [7:0]     flight_reg;
    logic [AW-1:0]  head_reg;
    logic [CW-1:0]  count_reg;
    logic [2:0]     init_locks_reg;
    logic [7:0]     led_cmd_reg;

    // Second LED byte waiting for the RAM write port, and read forwarding.
    logic           pend_valid_reg;
    logic [AW-1:0]  pend_addr_reg;
    logic [7:0]     pend_data_reg;
    logic           fwd_hit_reg;
    logic [7:0]     fwd_data_reg;

    logic [AW-1:0]  head_next;
    logic [CW-1:0]  count_next;
    logic [AW-1:0]  head_inc;
    logic [AW-1:0]  tail0;
    logic [AW-1:0]  tail1;
    logic [CW-1:0]  count_pushed;

    ksd_pkg::step_t   step;
    ksd_pkg::result_t res0;
    ksd_pkg::result_t res1;
    ksd_pkg::result_t out_data;

    logic           fire;
    logic           room2;
    logic           push0;
    logic           push1;
    logic           deq;
    logic [7:0]     deq_byte;
    logic [7:0]     head_data;
    logic [7:0]     ram_rdata;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [1:0]     push_cnt;

    // Wraps a queue index sum back into the queue's address range.
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] r;
        begin
            r = s;
            if (s >= (AW + 1)'(ksd_pkg::QUEUE_DEPTH))
            begin
                r = s - (AW + 1)'(ksd_pkg::QUEUE_DEPTH);
            end
            wrap = r[AW-1:0];
        end
    endfunction

    assign fire     = in_valid && in_ready;
    assign in_ready = !pend_valid_reg && room2;

    // Key decoding.
    ksd_decode u_decode (
        .opcode         (opcode),
        .scan_byte      (scan_byte),
        .shift_bits     (shift_reg),
        .lock_bits      (lock_reg),
        .focus_bit      (focus_reg),
        .awaiting       (await_reg),
        .byte_in_flight (flight_reg),
        .initial_locks  (init_locks_reg),
        .step           (step)
    );

    // Queue bookkeeping: pushes of the LED bytes, then the send of the oldest byte.
    always_comb
    begin
        tail0        = wrap({1'b0, head_reg} + (AW + 1)'(count_reg));
        tail1        = wrap({1'b0, tail0} + (AW + 1)'(1));
        head_inc     = wrap({1'b0, head_reg} + (AW + 1)'(1));
        push0        = fire && step.led_update &&
                       (count_reg < CW'(ksd_pkg::QUEUE_DEPTH));
        push1        = fire && step.led_update &&
                       (count_reg < CW'(ksd_pkg::QUEUE_DEPTH - 1));
        count_pushed = count_reg + CW'(push0) + CW'(push1);
        deq          = fire && (count_pushed != '0) && !step.awaiting;
        head_data    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        // An empty queue sends the command byte that was just pushed.
        deq_byte     = (count_reg != '0) ? head_data : led_cmd_reg;
        head_next    = deq ? head_inc : head_reg;
        count_next   = count_pushed - CW'(deq);
    end

    // Queue RAM write port: the deferred second byte has priority.
    always_comb
    begin
        ram_we    = pend_valid_reg || push0;
        ram_waddr = pend_valid_reg ? pend_addr_reg : tail0;
        ram_wdata = pend_valid_reg ? pend_data_reg : led_cmd_reg;
    end

    ksd_ram #(
        .WIDTH (8),
        .DEPTH (ksd_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // Result beats for this item: key event first, then the byte sent.
    always_comb
    begin
        res1.kind  = ksd_pkg::KIND_TX;
        res1.value = deq_byte;
        res1.focus = step.focus;
        res1.last  = 1'b1;
        if (step.ev_valid)
        begin
            res0.kind  = step.ev_kind;
            res0.value = step.ev_value;
            res0.focus = step.focus;
            res0.last  = !deq;
        end
        else
        begin
            res0 = res1;
        end
        push_cnt = fire ? (2'(step.ev_valid) + 2'(deq)) : 2'd0;
    end

    ksd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind  = out_data.kind;
    assign value = out_data.value;
    assign focus = out_data.focus;
    assign last  = out_data.last;

    // Decoder state, queue pointers and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            lock_reg       <= '0;
            focus_reg      <= 1'b0;
            await_reg      <= 1'b0;
            flight_reg     <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            init_locks_reg <= '0;
            led_cmd_reg    <= ksd_pkg::LED_CMD_RESET;
        end
        else
        begin
            if (fire)
            begin
                shift_reg <= step.shift;
                lock_reg  <= step.locks;
                focus_reg <= step.focus;
                await_reg <= deq ? 1'b1 : step.awaiting;
            end
            if (deq)
            begin
                flight_reg <= deq_byte;
            end
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= push1;
            fwd_hit_reg    <= ram_we && (ram_waddr == head_next);
            if (cfg_write)
            begin
                case (cfg_index)
                    ksd_pkg::CFG_INIT_LOCKS: init_locks_reg <= cfg_data[2:0];
                    ksd_pkg::CFG_LED_CMD:    led_cmd_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload of the deferred write and of the forwarded read.
    always_ff @(posedge clk)
    begin
        if (push1)
        begin
            pend_addr_reg <= tail1;
            pend_data_reg <= {5'b0, step.locks};
        end
        fwd_data_reg <= ram_wdata;
    end

endmodule

// ----- hw/rtl/ksd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ksd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/ksd_decode.sv -----
// Key decoding: layout lookup, case folding, modifier, lock and focus updates.
`timescale 1ns / 1ps

module ksd_decode (
    input  logic           opcode,
    input  logic [7:0]     scan_byte,
    input  logic [1:0]     shift_bits,
    input  logic [2:0]     lock_bits,
    input  logic           focus_bit,
    input  logic           awaiting,
    input  logic [7:0]     byte_in_flight,
    input  logic [2:0]     initial_locks,
    output ksd_pkg::step_t step
);

    logic [7:0] chr;
    logic       shifted;

    assign shifted = (shift_bits != 2'b00);

    always_comb
    begin
        step            = '0;
        step.shift      = shift_bits;
        step.locks      = lock_bits;
        step.focus      = focus_bit;
        step.awaiting   = awaiting;
        step.ev_kind    = ksd_pkg::KIND_CHAR;
        step.ev_value   = ksd_pkg::CHR_NONE;
        chr             = ksd_pkg::CHR_NONE;

        if (opcode == ksd_pkg::OP_INIT)
        begin
            // Load the firmware lock bits and send them to the keyboard.
            step.locks      = initial_locks;
            step.led_update = 1'b1;
        end
        else
        begin
            // Printable characters from the lower half of the code space.
            if (!scan_byte[7])
            begin
                chr = shifted ? ksd_pkg::SHIFT_MAP[scan_byte[6:0]]
                              : ksd_pkg::PLAIN_MAP[scan_byte[6:0]];
                if ((chr inside {[8'h41:8'h5a]}) && (lock_bits[2] == shifted))
                begin
                    chr = chr + ksd_pkg::CASE_OFFSET;
                end
                if (chr != ksd_pkg::CHR_NONE)
                begin
                    step.ev_valid = 1'b1;
                    step.ev_kind  = ksd_pkg::KIND_CHAR;
                    step.ev_value = chr;
                end
            end

            // Special keys and keyboard replies.
            case (scan_byte)
                ksd_pkg::SC_BACKSPACE:
                begin
                    step.ev_valid = 1'b1;
                    step.ev_kind  = ksd_pkg::KIND_BKSP;
                    step.ev_value = ksd_pkg::CHR_BACKSPACE;
                end
                ksd_pkg::SC_ENTER:
                begin
                    if (focus_bit)
                    begin
                        step.ev_valid = 1'b1;
                        step.ev_kind  = ksd_pkg::KIND_ENTER;
                        step.ev_value = ksd_pkg::CHR_ENTER;
                    end
                end
                ksd_pkg::SC_TAB:
                begin
                    step.focus    = ~focus_bit;
                    step.ev_valid = 1'b1;
                    step.ev_kind  = ksd_pkg::KIND_FOCUS;
                    step.ev_value = ksd_pkg::CHR_NONE;
                end
                ksd_pkg::SC_LSHIFT:     step.shift = shift_bits | 2'b01;
                ksd_pkg::SC_RSHIFT:     step.shift = shift_bits | 2'b10;
                ksd_pkg::SC_LSHIFT_REL: step.shift = shift_bits & 2'b10;
                ksd_pkg::SC_RSHIFT_REL: step.shift = shift_bits & 2'b01;
                ksd_pkg::SC_CAPS:
                begin
                    step.locks      = lock_bits ^ 3'b100;
                    step.led_update = 1'b1;
                end
                ksd_pkg::SC_NUM:
                begin
                    step.locks      = lock_bits ^ 3'b010;
                    step.led_update = 1'b1;
                end
                ksd_pkg::SC_SCROLL:
                begin
                    step.locks      = lock_bits ^ 3'b001;
                    step.led_update = 1'b1;
                end
                ksd_pkg::SC_ACK:
                begin
                    step.awaiting = 1'b0;
                end
                ksd_pkg::SC_RESEND:
                begin
                    if (awaiting)
                    begin
                        step.ev_valid = 1'b1;
                        step.ev_kind  = ksd_pkg::KIND_TX;
                        step.ev_value = byte_in_flight;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/ksd_out_fifo.sv -----
// Result buffer: takes up to two beats per cycle, delivers one per cycle while out_ready is high.
`timescale 1ns / 1ps

module ksd_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_cnt,
    input  ksd_pkg::result_t   push0,
    input  ksd_pkg::result_t   push1,
    output logic               room2,
    output logic               out_valid,
    input  logic               out_ready,
    output ksd_pkg::result_t   out_data
);

    ksd_pkg::result_t                 entry_reg [ksd_pkg::OFIFO_DEPTH];
    logic [ksd_pkg::OF_ADDR_W-1:0]    wr_ptr_reg;
    logic [ksd_pkg::OF_ADDR_W-1:0]    wr_ptr_next;
    logic [ksd_pkg::OF_ADDR_W-1:0]    wr_ptr_inc;
    logic [ksd_pkg::OF_ADDR_W-1:0]    rd_ptr_reg;
    logic [ksd_pkg::OF_ADDR_W-1:0]    rd_ptr_next;
    logic [ksd_pkg::OF_CNT_W-1:0]     count_reg;
    logic [ksd_pkg::OF_CNT_W-1:0]     count_next;
    logic                             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign room2     = (count_reg <= ksd_pkg::OF_CNT_W'(ksd_pkg::OFIFO_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    // Pointer and fill count arithmetic.
    always_comb
    begin
        wr_ptr_inc  = wr_ptr_reg + ksd_pkg::OF_ADDR_W'(1);
        wr_ptr_next = wr_ptr_reg + ksd_pkg::OF_ADDR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + ksd_pkg::OF_ADDR_W'(pop);
        count_next  = count_reg + ksd_pkg::OF_CNT_W'(push_cnt) - ksd_pkg::OF_CNT_W'(pop);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push1;
        end
    end

endmodule

// ----- tb/tb_keyboard_scancode_decoder.sv -----
// Self-checking testbench for the keyboard scancode decoder with its LED command queue.
`timescale 1ns / 1ps

module tb_keyboard_scancode_decoder;

    import ksd_pkg::*;

    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 8;

    // Stimulus mixes for the random phases.
    localparam int MODE_TYPING = 0;
    localparam int MODE_FLOOD  = 1;
    localparam int MODE_ACKS   = 2;

    localparam logic [7:0] LOCK_KEYS  [3] = '{SC_CAPS, SC_NUM, SC_SCROLL};
    localparam logic [7:0] EDIT_KEYS  [3] = '{SC_BACKSPACE, SC_ENTER, SC_TAB};
    localparam logic [7:0] SHIFT_KEYS [4] = '{SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_REL,
                                              SC_RSHIFT_REL};

    // One row of the directed sequence; typed rows with nonzero n_res carry their single expected beat.
    typedef struct packed {
        logic       op;
        logic [7:0] sb;
        logic       typed;
        logic [1:0] n_res;
        kind_t      kind;
        logic [7:0] value;
        logic       focus;
    } dir_row_t;

    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{OP_SCAN, 8'h00,         1'b1, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h1e,         1'b1, 2'd1, KIND_CHAR,  8'h61,         1'b0},
        '{OP_SCAN, SC_BACKSPACE,  1'b1, 2'd1, KIND_BKSP,  CHR_BACKSPACE, 1'b0},
        '{OP_SCAN, SC_ENTER,      1'b1, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_TAB,        1'b1, 2'd1, KIND_FOCUS, CHR_NONE,      1'b1},
        '{OP_SCAN, SC_ENTER,      1'b1, 2'd1, KIND_ENTER, CHR_ENTER,     1'b1},
        '{OP_SCAN, SC_RESEND,     1'b1, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_ACK,        1'b1, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_CAPS,       1'b1, 2'd1, KIND_TX,    LED_CMD_RESET, 1'b1},
        '{OP_SCAN, SC_RESEND,     1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_ACK,        1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_LSHIFT,     1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h1e,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h02,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_LSHIFT_REL, 1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_RSHIFT,     1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h7d,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_RSHIFT_REL, 1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h7f,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'hff,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_INIT, 8'hff,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_ACK,        1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_ACK,        1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_NUM,        1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_SCROLL,     1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h39,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, SC_TAB,        1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0},
        '{OP_SCAN, 8'h80,         1'b0, 2'd0, KIND_CHAR,  CHR_NONE,      1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] scan_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       focus;
    logic       last;

    keyboard_scancode_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .scan_byte (scan_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .focus     (focus),
        .last      (last)
    );

    // Layout tables of the predictor, built from key rows at start-up.
    logic [7:0] plain_keys   [0:127];
    logic [7:0] shifted_keys [0:127];

    // Predicted decoder state and configuration.
    logic [1:0] kb_shift;
    logic [2:0] kb_locks;
    logic       kb_focus;
    logic [7:0] led_q [0:QUEUE_DEPTH-1];
    logic [4:0] led_head;
    logic [5:0] led_count;
    logic [7:0] led_inflight;
    logic       led_waiting;
    logic [2:0] cfg_init_locks;
    logic [7:0] cfg_led_cmd;

    result_t step_beats[$];
    result_t expected_beats[$];

    int  fail_count;
    int  items_fed;
    int  beats_seen;
    int  tx_beats;
    bit  in_quiet;
    bit  out_quiet;

    // Write one row of key characters into a layout table.
    function automatic void place_keys(input bit shifted, input int base, input string keys);
        for (int i = 0; i < keys.len(); i++)
        begin
            if (shifted)
                shifted_keys[base + i] = keys[i];
            else
                plain_keys[base + i] = keys[i];
        end
    endfunction

    function automatic result_t make_beat(input kind_t k, input logic [7:0] v);
        result_t r;
        r.kind  = k;
        r.value = v;
        r.focus = kb_focus;
        r.last  = 1'b0;
        return r;
    endfunction

    // A byte that finds the command queue full is lost.
    function automatic void push_led_byte(input logic [7:0] b);
        if (led_count < QUEUE_DEPTH)
        begin
            led_q[5'(led_head + led_count[4:0])] = b;
            led_count = led_count + 6'd1;
        end
    endfunction

    function automatic void queue_led_update();
        push_led_byte(cfg_led_cmd);
        push_led_byte({5'd0, kb_locks});
    endfunction

    // Advance the predicted state by one item and leave its beats in step_beats.
    function automatic void decode_scan_item(input logic op, input logic [7:0] sb);
        logic [7:0] ch;
        step_beats.delete();
        if (op == OP_INIT)
        begin
            kb_locks = cfg_init_locks;
            queue_led_update();
        end
        else
        begin
            // Only make codes index the layout; letters turn lower case unless caps XOR shift.
            if (!sb[7])
            begin
                ch = (kb_shift != 2'b00) ? shifted_keys[sb[6:0]] : plain_keys[sb[6:0]];
                if (ch >= "A" && ch <= "Z" && (kb_locks[2] == (kb_shift != 2'b00)))
                    ch = ch + CASE_OFFSET;
                if (ch != CHR_NONE)
                    step_beats.push_back(make_beat(KIND_CHAR, ch));
            end
            case (sb)
                SC_BACKSPACE:  step_beats.push_back(make_beat(KIND_BKSP, CHR_BACKSPACE));
                SC_ENTER:
                begin
                    if (kb_focus)
                        step_beats.push_back(make_beat(KIND_ENTER, CHR_ENTER));
                end
                SC_TAB:
                begin
                    kb_focus = ~kb_focus;
                    step_beats.push_back(make_beat(KIND_FOCUS, CHR_NONE));
                end
                SC_LSHIFT:     kb_shift[0] = 1'b1;
                SC_RSHIFT:     kb_shift[1] = 1'b1;
                SC_LSHIFT_REL: kb_shift[0] = 1'b0;
                SC_RSHIFT_REL: kb_shift[1] = 1'b0;
                SC_CAPS:
                begin
                    kb_locks[2] = ~kb_locks[2];
                    queue_led_update();
                end
                SC_NUM:
                begin
                    kb_locks[1] = ~kb_locks[1];
                    queue_led_update();
                end
                SC_SCROLL:
                begin
                    kb_locks[0] = ~kb_locks[0];
                    queue_led_update();
                end
                SC_ACK:        led_waiting = 1'b0;
                SC_RESEND:
                begin
                    if (led_waiting)
                        step_beats.push_back(make_beat(KIND_TX, led_inflight));
                end
                default: ;
            endcase
        end
        // Send the oldest queued byte once nothing is in flight.
        if (led_count != 0 && !led_waiting)
        begin
            led_inflight = led_q[led_head];
            led_head     = led_head + 5'd1;
            led_count    = led_count - 6'd1;
            led_waiting  = 1'b1;
            step_beats.push_back(make_beat(KIND_TX, led_inflight));
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
    endfunction

    // Draw one random item according to the mix of the current phase.
    function automatic void pick_random(input int mode, output logic op,
                                        output logic [7:0] sb);
        int r;
        r  = $urandom_range(0, 99);
        op = OP_SCAN;
        sb = 8'($urandom_range(0, 127));
        if (mode == MODE_FLOOD)
        begin
            // No acknowledges, so the command queue fills and overflows.
            if (r >= 40 && r < 85)
                sb = LOCK_KEYS[$urandom_range(0, 2)];
            else if (r >= 85)
            begin
                op = OP_INIT;
                sb = 8'($urandom_range(0, 255));
            end
        end
        else if (mode == MODE_ACKS && r >= 55)
            sb = SC_ACK;
        else if (r >= 30 && r < 40)
            sb = 8'($urandom_range(0, 255));
        else if (r >= 40 && r < 52)
            sb = EDIT_KEYS[$urandom_range(0, 2)];
        else if (r >= 52 && r < 64)
            sb = SHIFT_KEYS[$urandom_range(0, 3)];
        else if (r >= 64 && r < 72)
            sb = LOCK_KEYS[$urandom_range(0, 2)];
        else if (r >= 72 && r < 88)
            sb = SC_ACK;
        else if (r >= 88 && r < 93)
            sb = SC_RESEND;
        else if (r >= 93 && r < 97)
        begin
            op = OP_INIT;
            sb = 8'($urandom_range(0, 255));
        end
        else if (r >= 97)
            sb = 8'($urandom_range(128, 255));
    endfunction

    // Present one input beat after a random gap and wait until it is taken.
    task automatic feed_item(input logic op, input logic [7:0] sb);
        int gap;
        if (items_fed % 32 == 0)
            in_quiet = ($urandom_range(0, 3) == 0);
        gap = in_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        scan_byte <= sb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_fed++;
    endtask

    // Wait for every expected beat plus the block's own latency.
    task automatic settle();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write both registers on consecutive edges while the block is idle.
    task automatic write_config(input logic [2:0] locks_val, input logic [7:0] led_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_INIT_LOCKS;
        cfg_data  <= {5'd0, locks_val};
        @(posedge clk);
        cfg_index <= CFG_LED_CMD;
        cfg_data  <= led_val;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_init_locks = locks_val;
        cfg_led_cmd    = led_val;
    endtask

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stimulus: reset, directed table, then randomized phases under several settings.
    initial
    begin
        logic       op;
        logic [7:0] sb;
        logic [2:0] locks_val;
        logic [7:0] led_val;
        int         mode;
        result_t    typed_beat;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_INIT_LOCKS;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        opcode    = OP_SCAN;
        scan_byte = 8'd0;
        fail_count = 0;
        items_fed  = 0;
        beats_seen = 0;
        tx_beats   = 0;
        in_quiet   = 1'b0;

        for (int i = 0; i < 128; i++)
        begin
            plain_keys[i]   = CHR_NONE;
            shifted_keys[i] = CHR_NONE;
        end
        place_keys(1'b0, 8'h02, "1234567890-^");
        place_keys(1'b0, 8'h10, "QWERTYUIOP@[");
        place_keys(1'b0, 8'h1e, "ASDFGHJKL;:");
        place_keys(1'b0, 8'h2b, "]ZXCVBNM,./");
        place_keys(1'b0, 8'h37, "*");
        place_keys(1'b0, 8'h39, " ");
        place_keys(1'b0, 8'h47, "789-456+1230.");
        plain_keys[8'h73] = 8'h5c;
        plain_keys[8'h7d] = 8'h5c;
        place_keys(1'b1, 8'h02, "!\"#$%&'()~=~");
        place_keys(1'b1, 8'h10, "QWERTYUIOP`{");
        place_keys(1'b1, 8'h1e, "ASDFGHJKL+*");
        place_keys(1'b1, 8'h2b, "}ZXCVBNM<>?");
        place_keys(1'b1, 8'h37, "*");
        place_keys(1'b1, 8'h39, " ");
        place_keys(1'b1, 8'h47, "789-456+1230.");
        place_keys(1'b1, 8'h73, "_");
        place_keys(1'b1, 8'h7d, "|");

        kb_shift       = 2'b00;
        kb_locks       = 3'b000;
        kb_focus       = 1'b0;
        led_head       = 5'd0;
        led_count      = 6'd0;
        led_inflight   = 8'd0;
        led_waiting    = 1'b0;
        cfg_init_locks = 3'd0;
        cfg_led_cmd    = LED_CMD_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset configuration.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            feed_item(DIR_TAB[i].op, DIR_TAB[i].sb);
            decode_scan_item(DIR_TAB[i].op, DIR_TAB[i].sb);
            if (DIR_TAB[i].typed)
            begin
                if (DIR_TAB[i].n_res != 0)
                begin
                    typed_beat.kind  = DIR_TAB[i].kind;
                    typed_beat.value = DIR_TAB[i].value;
                    typed_beat.focus = DIR_TAB[i].focus;
                    typed_beat.last  = 1'b1;
                    expected_beats.push_back(typed_beat);
                end
            end
            else
            begin
                foreach (step_beats[j])
                    expected_beats.push_back(step_beats[j]);
            end
        end
        in_valid <= 1'b0;
        settle();

        // Random phases, each under its own register setting and stimulus mix.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin locks_val = 3'd7; led_val = 8'hff; end
                1:       begin locks_val = 3'd0; led_val = 8'h00; end
                3:       begin locks_val = 3'd5; led_val = SC_ACK; end
                5:       begin locks_val = 3'd2; led_val = LED_CMD_RESET; end
                default:
                begin
                    locks_val = 3'($urandom_range(0, 7));
                    led_val   = 8'($urandom_range(0, 255));
                end
            endcase
            mode = (p % 3 == 1) ? MODE_FLOOD : ((p % 3 == 2) ? MODE_ACKS : MODE_TYPING);
            write_config(locks_val, led_val);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick_random(mode, op, sb);
                feed_item(op, sb);
                decode_scan_item(op, sb);
                foreach (step_beats[j])
                    expected_beats.push_back(step_beats[j]);
            end
            in_valid <= 1'b0;
            settle();
        end

        $display("Run covered %0d input beats (%0d directed) over %0d register settings;",
                 items_fed, DIR_ROWS, PHASES + 1);
        $display("%0d result beats checked, %0d of them bytes sent to the keyboard.",
                 beats_seen, tx_beats);
        if (fail_count == 0)
            $display("tb_keyboard_scancode_decoder: PASS");
        else
            $display("tb_keyboard_scancode_decoder: FAIL");
        $finish;
    end

    // Result side: random back-pressure and field-by-field comparison.
    initial
    begin
        int      gap;
        int      taken;
        result_t got;
        result_t want;

        out_ready = 1'b0;
        out_quiet = 1'b0;
        taken     = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                out_quiet = ($urandom_range(0, 3) == 0);
            gap = out_quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
            beats_seen++;
            got.kind  = kind_t'(kind);
            got.value = value;
            got.focus = focus;
            got.last  = last;
            if (got.kind == KIND_TX)
                tx_beats++;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d value 0x%02h",
                       got.kind, got.value);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    fail_count++;
                end
                if (got.value !== want.value)
                begin
                    $error("value: expected 0x%02h, got 0x%02h", want.value, got.value);
                    fail_count++;
                end
                if (got.focus !== want.focus)
                begin
                    $error("focus: expected %0d, got %0d", want.focus, got.focus);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on either channel ends the run.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("tb_keyboard_scancode_decoder: FAIL");
        $finish;
    end

endmodule
